[rtl/lru_replacement_with_pins_defines.svh]
// Assertion macros for the checker file of the replacement block.
// No dependencies; include by bare file name.
`ifndef LRU_REPLACEMENT_WITH_PINS_DEFINES_SVH
`define LRU_REPLACEMENT_WITH_PINS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lrup assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRUP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lrup assertion failed");

// Delayed implication, disabled while reset is asserted.
`define LRUP_ASSERT_DLY2(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
	else $error("lrup assertion failed");

`endif

[rtl/lrup_pkg.sv]
// Package for the replacement block: sizes, op codes, word and cell structs.
// No dependencies; imported by every module of the block.
`default_nettype none

package lrup_pkg;

	// Number of entries and derived widths.
	localparam int ENTRIES    = 16;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int RANK_W     = $clog2(ENTRIES + 1);
	localparam int CNT_W      = 8;
	localparam int WIDE_IDX_W = ((IDX_W > 4) ? IDX_W : 4) + 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Operation codes of the request word.
	localparam logic [2:0] OP_TOUCH   = 3'd0;
	localparam logic [2:0] OP_ALLOC   = 3'd1;
	localparam logic [2:0] OP_ACQUIRE = 3'd2;
	localparam logic [2:0] OP_RELEASE = 3'd3;
	localparam logic [2:0] OP_COMMIT  = 3'd4;

	// Request word.
	typedef struct packed {
		logic [2:0] op;
		logic [3:0] entry_index;
	} req_t;

	// Response word.
	typedef struct packed {
		logic       victim_found;
		logic [3:0] victim_index;
		logic [7:0] user_count_now;
		logic [4:0] rank_now;
	} rsp_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic              do_touch;
		logic              do_acq;
		logic              do_rel;
		logic              do_commit;
		logic              do_reserve;
		logic [IDX_W-1:0]  sel;
		logic [RANK_W-1:0] old_rank;
	} cell_cmd_t;

	// Victim candidate handed from cell to cell.
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [RANK_W-1:0] rank;
	} cand_t;

	// Rank and count seen at a cell.
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [CNT_W-1:0]  count;
	} cell_view_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

endpackage

`default_nettype wire

[rtl/lrup_cell.sv]
// One entry of the replacement chain: rank, user count, reserved mark and
// one stage of the victim search. Depends on lrup_pkg.
`default_nettype none

module lrup_cell import lrup_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] my_idx,
	input  cell_cmd_t        cmd,
	input  cand_t            cand_in,
	output cand_t            cand_out,
	output cell_view_t       cur,
	output cell_view_t       nxt
);

	logic [RANK_W-1:0] rank_q, rank_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              rsv_q, rsv_d;
	cand_t             cand_q, cand_d;
	logic              hit;
	logic              free;

	// Apply the broadcast command to this entry.
	always_comb begin
		hit     = (cmd.sel == my_idx);
		rank_d  = rank_q;
		count_d = count_q;
		rsv_d   = rsv_q;
		if (cmd.do_touch && cmd.old_rank != RANK_W'(1)) begin
			if (hit) begin
				rank_d = RANK_W'(1);
			end else if (rank_q < cmd.old_rank) begin
				rank_d = rank_q + RANK_W'(1);
			end
		end
		if (hit && cmd.do_acq && count_q != CNT_MAX) begin
			count_d = count_q + CNT_W'(1);
		end
		if (hit && cmd.do_rel && count_q != '0) begin
			count_d = count_q - CNT_W'(1);
		end
		if (hit && cmd.do_commit) begin
			rsv_d   = 1'b0;
			count_d = CNT_W'(1);
		end
		if (hit && cmd.do_reserve) begin
			rsv_d = 1'b1;
		end
	end

	// Search stage: keep the older free entry of the incoming one and this one.
	always_comb begin
		free   = (count_q == '0) && !rsv_q;
		cand_d = cand_in;
		if (free && (rank_q > cand_in.rank)) begin
			cand_d.found = 1'b1;
			cand_d.idx   = my_idx;
			cand_d.rank  = rank_q;
		end
	end

	// Entry state; reset puts entry i at rank i plus one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q  <= RANK_W'(my_idx) + RANK_W'(1);
			count_q <= '0;
			rsv_q   <= 1'b0;
			cand_q  <= '0;
		end else begin
			rank_q  <= rank_d;
			count_q <= count_d;
			rsv_q   <= rsv_d;
			cand_q  <= cand_d;
		end
	end

	assign cand_out   = cand_q;
	assign cur.rank   = rank_q;
	assign cur.count  = count_q;
	assign nxt.rank   = rank_d;
	assign nxt.count  = count_d;

endmodule

`default_nettype wire

[rtl/lru_replacement_with_pins.sv]
// Top level of the replacement block: controller and the chain of entry cells.
// Depends on lrup_pkg and lrup_cell.
//
// Usage:
// A request word (req: op and entry_index) is taken at a rising edge where
// start is high and busy is low. Exactly one response word appears on rsp
// for one cycle, marked by done; the receiver cannot stall it.
// Touch, acquire, release, commit and unused op codes: the word is applied
// in the cycle after the accept and done is high in the cycle after that,
// during which busy is already low and the next word can be taken. For
// allocate the victim search comes first: a candidate walks the row of
// cells one cell per cycle, then the apply state reserves the winner, and
// done follows as for the other words. An entry_index at or beyond ENTRIES
// leaves the state alone and answers with zeros. Reset (arst_n low) puts
// entry i at rank i plus one, clears all user counts and reserved marks,
// and drops busy and done at once.
`default_nettype none

module lru_replacement_with_pins import lrup_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  scan_q;
	logic [2:0]        op_q;
	logic [3:0]        idx_q;
	rsp_t              rsp_q, rsp_d;
	logic              done_q;

	cand_t             cand_chain [ENTRIES+1];
	cell_view_t        cur_view   [ENTRIES];
	cell_view_t        nxt_view   [ENTRIES];
	cell_cmd_t         cmd;

	logic [WIDE_IDX_W-1:0] idx_w;
	logic                  is_alloc;
	logic                  ok;
	logic [IDX_W-1:0]      sel;
	cand_t                 best;

	// Row of entry cells; the search candidate enters the first with nothing found.
	assign cand_chain[0] = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lrup_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (IDX_W'(g)),
			.cmd     (cmd),
			.cand_in (cand_chain[g]),
			.cand_out(cand_chain[g+1]),
			.cur     (cur_view[g]),
			.nxt     (nxt_view[g])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (req.op == OP_ALLOC) ? ST_SCAN : ST_APPLY;
				end
			end
			ST_SCAN: begin
				if (scan_q == IDX_W'(ENTRIES - 1)) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Decode of the held word and the winner at the end of the chain.
	always_comb begin
		idx_w    = WIDE_IDX_W'(idx_q);
		is_alloc = (op_q == OP_ALLOC);
		best     = cand_chain[ENTRIES];
		sel      = is_alloc ? best.idx : idx_w[IDX_W-1:0];
		ok       = is_alloc ? best.found
		                    : ((op_q <= OP_COMMIT) && (idx_w < WIDE_IDX_W'(ENTRIES)));
	end

	// Outputs of the controller: cell command and response word.
	always_comb begin
		busy  = 1'b1;
		cmd   = '0;
		rsp_d = '0;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_SCAN: busy = 1'b1;
			ST_APPLY: begin
				if (ok) begin
					cmd.do_touch   = (op_q == OP_TOUCH);
					cmd.do_acq     = (op_q == OP_ACQUIRE);
					cmd.do_rel     = (op_q == OP_RELEASE);
					cmd.do_commit  = (op_q == OP_COMMIT);
					cmd.do_reserve = is_alloc;
					cmd.sel        = sel;
					cmd.old_rank   = cur_view[sel].rank;
					rsp_d.victim_found   = is_alloc;
					rsp_d.victim_index   = is_alloc ? 4'(sel) : 4'd0;
					rsp_d.user_count_now = nxt_view[sel].count;
					rsp_d.rank_now       = 5'(nxt_view[sel].rank);
				end
			end
			default: busy = 1'b1;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= (state_q == ST_SCAN) ? scan_q + IDX_W'(1) : '0;
			done_q  <= (state_q == ST_APPLY);
		end
	end

	// Held request and registered response.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q  <= req.op;
			idx_q <= req.entry_index;
		end
		if (state_q == ST_APPLY) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[rtl/lrup_checker.sv]
// Port-level checker for the replacement block and its bind to the top level.
// Depends on lrup_pkg and lru_replacement_with_pins_defines.svh.
`default_nettype none
`include "lru_replacement_with_pins_defines.svh"

module lrup_checker import lrup_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// A word other than allocate is answered through the apply state and the done register.
	`LRUP_ASSERT_DLY2(a_short_latency, clk, arst_n, start && !busy && req.op != OP_ALLOC, done)

	// The busy flag drops only as a response goes out.
	`LRUP_ASSERT_IMP(a_idle_with_done, clk, arst_n, $fell(busy), done)

	// Without a victim the victim index reads zero.
	`LRUP_ASSERT_IMP(a_no_victim_zero, clk, arst_n, done && !rsp.victim_found, rsp.victim_index == 4'd0)

	// A chosen victim never has users.
	`LRUP_ASSERT_IMP(a_victim_unused, clk, arst_n, done && rsp.victim_found, rsp.user_count_now == 8'd0)

	// A response is a single-cycle strobe.
	`LRUP_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)

endmodule

bind lru_replacement_with_pins lrup_checker u_lrup_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);

`default_nettype wire

[tb/tb_lru_replacement_with_pins.sv]
// Self-checking testbench for lru_replacement_with_pins: directed and random words.
// It keeps its own copy of ranks, user counts and reserved marks to predict each response.
// Depends on lrup_pkg and the RTL of the block only.
`default_nettype none

module tb_lru_replacement_with_pins;
	import lrup_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Op codes the block decodes as no operation.
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
	localparam int MAX_REPORTS   = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Shadow copy of the replacement state.
	logic [RANK_W-1:0] shadow_rank [ENTRIES];
	logic [CNT_W-1:0]  shadow_users [ENTRIES];
	logic              shadow_reserved [ENTRIES];

	// Responses predicted for accepted words, oldest first.
	rsp_t answers_due [$];
	rsp_t oldest_answer;

	int idle_pct = 0;
	int words_sent = 0;
	int answers_seen = 0;
	int fault_count = 0;
	int victims_granted = 0;
	int alloc_refused = 0;
	int op_tally [8];
	int cycles = 0;

	lru_replacement_with_pins dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	function automatic req_t make_word(logic [2:0] op, int idx);
		req_t w;
		w.op = op;
		w.entry_index = 4'(idx);
		return w;
	endfunction

	// Applies one word to the shadow state and returns the response it must cause.
	function automatic rsp_t apply_lru_op(req_t w);
		rsp_t r;
		int e;
		int best;
		logic [RANK_W-1:0] best_rank;
		logic [RANK_W-1:0] old_rank;
		r = '0;
		e = int'(w.entry_index);
		if (w.op == OP_ALLOC) begin
			best = -1;
			best_rank = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (shadow_users[i] == '0 && !shadow_reserved[i] && shadow_rank[i] > best_rank) begin
					best_rank = shadow_rank[i];
					best = i;
				end
			end
			if (best >= 0) begin
				shadow_reserved[best] = 1'b1;
				r.victim_found = 1'b1;
				r.victim_index = 4'(best);
				r.user_count_now = shadow_users[best];
				r.rank_now = 5'(shadow_rank[best]);
			end
		end else if (w.op <= OP_COMMIT && e < ENTRIES) begin
			case (w.op)
				OP_TOUCH: begin
					// Only entries more recent than the touched one age.
					old_rank = shadow_rank[e];
					if (old_rank != RANK_W'(1)) begin
						for (int i = 0; i < ENTRIES; i++)
							if (i != e && shadow_rank[i] < old_rank)
								shadow_rank[i] = shadow_rank[i] + RANK_W'(1);
						shadow_rank[e] = RANK_W'(1);
					end
				end
				OP_ACQUIRE: begin
					if (shadow_users[e] != CNT_MAX)
						shadow_users[e] = shadow_users[e] + CNT_W'(1);
				end
				OP_RELEASE: begin
					if (shadow_users[e] != '0)
						shadow_users[e] = shadow_users[e] - CNT_W'(1);
				end
				default: begin
					shadow_reserved[e] = 1'b0;
					shadow_users[e] = CNT_W'(1);
				end
			endcase
			r.user_count_now = shadow_users[e];
			r.rank_now = 5'(shadow_rank[e]);
		end
		return r;
	endfunction

	// Sends one word, with an optional idle burst first, and predicts its response.
	task automatic issue_word(input req_t w, output rsp_t predicted);
		int gap;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(17, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		predicted = apply_lru_op(w);
		answers_due.push_back(predicted);
		words_sent++;
		op_tally[w.op]++;
		if (w.op == OP_ALLOC) begin
			if (predicted.victim_found)
				victims_granted++;
			else
				alloc_refused++;
		end
	endtask

	// Each response is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			answers_seen++;
			if (answers_due.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("response with none pending: %p", rsp);
			end else begin
				oldest_answer = answers_due.pop_front();
				if (rsp.victim_found !== oldest_answer.victim_found ||
				    rsp.victim_index !== oldest_answer.victim_index ||
				    rsp.user_count_now !== oldest_answer.user_count_now ||
				    rsp.rank_now !== oldest_answer.rank_now) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("response mismatch: expected %p, got %p", oldest_answer, rsp);
				end
			end
		end
	end

	// Touching the most recent entry, the least recent one and one in the middle.
	task automatic test_touch_order();
		rsp_t p;
		issue_word(make_word(OP_TOUCH, 0), p);
		issue_word(make_word(OP_TOUCH, ENTRIES - 1), p);
		issue_word(make_word(OP_TOUCH, 8), p);
		issue_word(make_word(OP_TOUCH, ENTRIES - 1), p);
		issue_word(make_word(OP_TOUCH, 0), p);
	endtask

	// Acquire and release, including release of an entry with no users.
	task automatic test_user_counts();
		rsp_t p;
		issue_word(make_word(OP_ACQUIRE, 3), p);
		issue_word(make_word(OP_ACQUIRE, 3), p);
		issue_word(make_word(OP_RELEASE, 3), p);
		issue_word(make_word(OP_RELEASE, 3), p);
		issue_word(make_word(OP_RELEASE, 3), p);
		issue_word(make_word(OP_RELEASE, 12), p);
	endtask

	// A full fill: allocate, count changes on the reserved victim, commit, then a touch and a release.
	task automatic test_alloc_commit();
		rsp_t p;
		int v;
		issue_word(make_word(OP_ALLOC, 5), p);
		v = int'(p.victim_index);
		issue_word(make_word(OP_ACQUIRE, v), p);
		issue_word(make_word(OP_RELEASE, v), p);
		issue_word(make_word(OP_COMMIT, v), p);
		issue_word(make_word(OP_TOUCH, v), p);
		issue_word(make_word(OP_RELEASE, v), p);
	endtask

	// Unused op codes must leave the state alone and answer with zeros.
	task automatic test_spare_ops();
		rsp_t p;
		issue_word(make_word(OP_SPARE5, ENTRIES - 1), p);
		issue_word(make_word(OP_SPARE6, 0), p);
		issue_word(make_word(OP_SPARE7, 10), p);
	endtask

	// Drives one user count into saturation and back down a little.
	task automatic test_count_saturation();
		rsp_t p;
		repeat (int'(CNT_MAX) + 2) issue_word(make_word(OP_ACQUIRE, 9), p);
		repeat (3) issue_word(make_word(OP_RELEASE, 9), p);
	endtask

	// Allocates until nothing is free, then returns every entry to the pool.
	task automatic test_no_free_entry();
		rsp_t p;
		int tries;
		tries = 0;
		p.victim_found = 1'b1;
		while (p.victim_found && tries <= ENTRIES) begin
			issue_word(make_word(OP_ALLOC, tries), p);
			tries++;
		end
		issue_word(make_word(OP_ALLOC, ENTRIES - 1), p);
		for (int e = 0; e < ENTRIES; e++) begin
			issue_word(make_word(OP_COMMIT, e), p);
			issue_word(make_word(OP_RELEASE, e), p);
		end
	endtask

	// Mostly fill sequences with random content, plus single ops and noise.
	task automatic test_random_traffic(input int total);
		rsp_t p;
		int issued;
		int pick;
		int v;
		logic [2:0] op;
		issued = 0;
		while (issued < total) begin
			if (total - issued <= 150)
				idle_pct = 0;
			else if (issued % 64 == 0)
				idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 10);
			pick = $urandom_range(99);
			if (pick < 35) begin
				issue_word(make_word(OP_ALLOC, $urandom_range(ENTRIES - 1)), p);
				issued++;
				if (p.victim_found) begin
					v = int'(p.victim_index);
					if ($urandom_range(1) == 0) begin
						issue_word(make_word(OP_TOUCH, v), p);
						issued++;
					end
					issue_word(make_word(OP_COMMIT, v), p);
					issued++;
					repeat ($urandom_range(2)) begin
						issue_word(make_word(OP_ACQUIRE, v), p);
						issued++;
					end
					repeat ($urandom_range(3)) begin
						issue_word(make_word(OP_RELEASE, v), p);
						issued++;
					end
				end
			end else if (pick < 80) begin
				pick = $urandom_range(99);
				if (pick < 30)
					op = OP_TOUCH;
				else if (pick < 42)
					op = OP_ALLOC;
				else if (pick < 57)
					op = OP_ACQUIRE;
				else if (pick < 87)
					op = OP_RELEASE;
				else
					op = OP_COMMIT;
				issue_word(make_word(op, $urandom_range(ENTRIES - 1)), p);
				issued++;
			end else begin
				issue_word(make_word(3'($urandom_range(7)), $urandom_range(15)), p);
				issued++;
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_rank[i] = RANK_W'(i + 1);
			shadow_users[i] = '0;
			shadow_reserved[i] = 1'b0;
		end
		for (int i = 0; i < 8; i++)
			op_tally[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_touch_order();
		test_user_counts();
		test_alloc_commit();
		test_spare_ops();
		idle_pct = 20;
		test_count_saturation();
		test_no_free_entry();
		test_random_traffic(750);

		// Let every response come back, then watch for stray ones.
		start <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d words (touch %0d, allocate %0d, acquire %0d, release %0d, commit %0d, spare %0d).",
			words_sent, op_tally[OP_TOUCH], op_tally[OP_ALLOC], op_tally[OP_ACQUIRE],
			op_tally[OP_RELEASE], op_tally[OP_COMMIT],
			op_tally[OP_SPARE5] + op_tally[OP_SPARE6] + op_tally[OP_SPARE7]);
		$display("Checked %0d responses; %0d victims granted, %0d allocations refused, %0d faults.",
			answers_seen, victims_granted, alloc_refused, fault_count);
		if (fault_count == 0 && answers_due.size() == 0)
			$display("tb_lru_replacement_with_pins: PASS");
		else
			$display("tb_lru_replacement_with_pins: FAIL");
		$finish;
	end

	// Watchdog on the cycle count.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d responses pending.",
			cycles, answers_due.size());
		$display("tb_lru_replacement_with_pins: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
